>>> hdl/rc4_pkg.sv
// rc4_pkg: shared types and codes of the rc4 stream cipher
// input op codes, controller states, datapath step codes and the cmd/status structs
// no dependencies
`timescale 1ns / 1ps

package rc4_pkg;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned BYTE_W     = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RI,
    ST_KS_RJ,
    ST_KS_WI,
    ST_KS_WJ,
    ST_DT_RI,
    ST_DT_RJ,
    ST_DT_WI,
    ST_DT_WJ,
    ST_DT_OUT
  } state_e;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_FILL,
    STEP_KS_RI,
    STEP_KS_RJ,
    STEP_KS_WI,
    STEP_KS_WJ,
    STEP_DT_RI,
    STEP_DT_RJ,
    STEP_DT_WI,
    STEP_DT_WJ,
    STEP_DT_OUT
  } step_e;

  typedef struct packed {
    logic  key_wr;
    logic  sched_start;
    logic  data_ld;
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic keyed;
    logic n_last;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/rc4_stream_cipher.sv
// rc4_stream_cipher: top level of the rc4 stream cipher
// depends on rc4_pkg, rc4_ctrl, rc4_dp (which holds two rc4_ram instances)
`timescale 1ns / 1ps
//
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+-----------------------------------------
// in      | input     | in_valid_i / in_ready_o | op_i, key_byte_i, key_last_i, data_byte_i
// out     | output    | out_valid_o / out_ready_i | data_out_o
//
// a key byte is taken in its transfer; the last key byte then starts an identity fill
//   of the permutation ram, then the swap steps read S[i], read S[j], write S[i], write S[j]
// a data byte passes the transfer, then read S[i], read S[j], write S[i], write S[j]
//   with read S[t] on the separate read port of the permutation ram, and the output load,
//   which waits for a free output register; the result is registered by the output load
// reset clears control state only; ram contents stay undefined and need no clearing pass
// in_ready_o is high whenever the sequencer is idle, also while a result waits in the
//   output register; only the output load of the next data byte stalls on out_ready_i

module rc4_stream_cipher #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] key_byte_i,
  input  logic       key_last_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o
);

  import rc4_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .op_i      (op_i),
    .key_last_i(key_last_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // permutation ram, key store, indices, key counter and output register
  rc4_dp #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .key_byte_i (key_byte_i),
    .data_byte_i(data_byte_i),
    .data_out_o (data_out_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

endmodule

>>> hdl/rc4_ram.sv
// rc4_ram: generic single-write, single-read ram with registered read (read-first)
// no dependencies
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/rc4_ctrl.sv
// rc4_ctrl: sequencing state machine for key load, key scheduling and data bytes
// depends on rc4_pkg
`timescale 1ns / 1ps

module rc4_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          op_i,
  input  logic          key_last_i,
  input  rc4_pkg::sts_t sts_i,
  output rc4_pkg::cmd_t cmd_o
);

  import rc4_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.step      = STEP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_KEY) begin
            cmd_o.key_wr = 1'b1;
            if (key_last_i) begin
              cmd_o.sched_start = 1'b1;
              state_d           = ST_FILL;
            end
          end else if (sts_i.keyed) begin
            cmd_o.data_ld = 1'b1;
            state_d       = ST_DT_RI;
          end
        end
      end
      ST_FILL: begin
        cmd_o.step = STEP_FILL;
        if (sts_i.n_last) begin
          state_d = ST_KS_RI;
        end
      end
      ST_KS_RI: begin
        cmd_o.step = STEP_KS_RI;
        state_d    = ST_KS_RJ;
      end
      ST_KS_RJ: begin
        cmd_o.step = STEP_KS_RJ;
        state_d    = ST_KS_WI;
      end
      ST_KS_WI: begin
        cmd_o.step = STEP_KS_WI;
        state_d    = ST_KS_WJ;
      end
      ST_KS_WJ: begin
        cmd_o.step = STEP_KS_WJ;
        state_d    = sts_i.n_last ? ST_IDLE : ST_KS_RI;
      end
      ST_DT_RI: begin
        cmd_o.step = STEP_DT_RI;
        state_d    = ST_DT_RJ;
      end
      ST_DT_RJ: begin
        cmd_o.step = STEP_DT_RJ;
        state_d    = ST_DT_WI;
      end
      ST_DT_WI: begin
        cmd_o.step = STEP_DT_WI;
        state_d    = ST_DT_WJ;
      end
      ST_DT_WJ: begin
        cmd_o.step = STEP_DT_WJ;
        state_d    = ST_DT_OUT;
      end
      ST_DT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.step = STEP_DT_OUT;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> hdl/rc4_dp.sv
// rc4_dp: permutation and key rams, index registers, key counter and output register
// depends on rc4_pkg and rc4_ram
`timescale 1ns / 1ps

module rc4_dp #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rc4_pkg::cmd_t cmd_i,
  output rc4_pkg::sts_t sts_o,
  input  logic [7:0]    key_byte_i,
  input  logic [7:0]    data_byte_i,
  output logic [7:0]    data_out_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  import rc4_pkg::*;

  localparam int unsigned KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned CW  = $clog2(MAX_KEY_BYTES + 1);

  logic [7:0]     i_q, i_d, j_q, j_d;
  logic [7:0]     si_q, si_d, sj_q, sj_d;
  logic [7:0]     data_q, out_q, out_d;
  logic           hit_q, hit_d;
  logic           keyed_q, keyed_d;
  logic           out_valid_q, out_valid_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [KAW-1:0] kpos_q, kpos_d;

  logic           s_we;
  logic [7:0]     s_waddr, s_wdata, s_raddr, s_rdata;
  logic           k_we;
  logic [7:0]     k_rdata;
  logic [7:0]     j_sum, t_addr;
  logic           cnt_room, kpos_wrap;

  assign cnt_room  = (cnt_q < CW'(MAX_KEY_BYTES));
  assign k_we      = cmd_i.key_wr && cnt_room;
  assign kpos_wrap = ((CW'(kpos_q) + CW'(1)) == cnt_q);
  assign t_addr    = si_q + sj_q;

  rc4_ram #(
    .DW   (BYTE_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  rc4_ram #(
    .DW   (BYTE_W),
    .DEPTH(MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (k_we),
    .waddr_i(cnt_q[KAW-1:0]),
    .wdata_i(key_byte_i),
    .raddr_i(kpos_q),
    .rdata_o(k_rdata)
  );

  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    hit_d       = hit_q;
    keyed_d     = keyed_q;
    cnt_d       = cnt_q;
    kpos_d      = kpos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    s_we        = 1'b0;
    s_waddr     = i_q;
    s_wdata     = i_q;
    s_raddr     = i_q;
    j_sum       = j_q + s_rdata;

    if (k_we) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.sched_start) begin
      i_d    = '0;
      j_d    = '0;
      kpos_d = '0;
    end

    unique case (cmd_i.step)
      STEP_NONE: begin
        // keep rereading S[t] while a result waits for the output register
        s_raddr = t_addr;
      end
      STEP_FILL: begin
        s_we = 1'b1;
        i_d  = i_q + 8'd1;
      end
      STEP_KS_RI: begin
        s_raddr = i_q;
      end
      STEP_KS_RJ: begin
        j_sum   = j_q + s_rdata + k_rdata;
        j_d     = j_sum;
        si_d    = s_rdata;
        s_raddr = j_sum;
      end
      STEP_KS_WI: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
      end
      STEP_KS_WJ: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        i_d     = i_q + 8'd1;
        kpos_d  = kpos_wrap ? '0 : kpos_q + KAW'(1);
        if (sts_o.n_last) begin
          j_d     = '0;
          cnt_d   = '0;
          kpos_d  = '0;
          keyed_d = 1'b1;
        end
      end
      STEP_DT_RI: begin
        i_d     = i_q + 8'd1;
        s_raddr = i_q + 8'd1;
      end
      STEP_DT_RJ: begin
        j_d     = j_sum;
        si_d    = s_rdata;
        s_raddr = j_sum;
      end
      STEP_DT_WI: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
        sj_d    = s_rdata;
      end
      STEP_DT_WJ: begin
        // read of S[t] sees old data where t == j, so remember the hit
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
        s_raddr = t_addr;
        hit_d   = (t_addr == j_q);
      end
      STEP_DT_OUT: begin
        out_d       = data_q ^ (hit_q ? si_q : s_rdata);
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      kpos_q      <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      kpos_q      <= kpos_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q  <= si_d;
    sj_q  <= sj_d;
    hit_q <= hit_d;
    out_q <= out_d;
    if (cmd_i.data_ld) begin
      data_q <= data_byte_i;
    end
  end

  assign sts_o.keyed    = keyed_q;
  assign sts_o.n_last   = (i_q == 8'hFF);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign data_out_o  = out_q;
  assign out_valid_o = out_valid_q;

  // once keyed, the block stays keyed
  a_keyed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyed_q |=> keyed_q)
    else $error("keyed flag dropped");

  // key count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_KEY_BYTES))
    else $error("key count overflow");

  // scheduling always runs with at least one key byte held
  a_ks_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == STEP_KS_RJ) |-> (cnt_q != '0))
    else $error("key schedule with empty key");

  // a result is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == STEP_DT_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote pending output");

  // data steps only run after a key has been scheduled
  a_data_keyed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == STEP_DT_RI) |-> keyed_q)
    else $error("data step before key schedule");

endmodule
